>>> hw/rtl/ptss_pkg.sv
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared sizes, codes and the slot entry layout of the periodic task slot
// scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

  // table geometry
  localparam int SLOTS       = 16;
  localparam int TICK_UNITS  = 10;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 32;
  localparam int TIME_W   = 16;
  localparam int SN_W     = 4;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int PEND_W   = 8;

  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // rounded-up reciprocal of the tick unit, exact for every TIME_W-bit dividend
  localparam int RECIP_SH = TIME_W + $clog2(TICK_UNITS);
  localparam int RECIP    = ((1 << RECIP_SH) + TICK_UNITS - 1) / TICK_UNITS;
  localparam int PROD_W   = TIME_W + RECIP_SH;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ADD      = 3'd1,
    FUNC_DELETE   = 3'd2,
    FUNC_DISPATCH = 3'd3,
    FUNC_FIND     = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  // one slot entry as kept in the table memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] cd;
    logic [TIME_W-1:0] rl;
    logic [PEND_W-1:0] pend;
  } slot_t;

endpackage

>>> hw/rtl/ptss_div.sv
// ----------------------------------------------------------------------------
// ptss_div
// Divide by the tick unit through a reciprocal multiply, quotient ready in the
// cycle after start.
// ----------------------------------------------------------------------------
module ptss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptss_pkg::TIME_W-1:0] dividend,
  output logic                        done,
  output logic [ptss_pkg::TIME_W-1:0] quotient
);
  import ptss_pkg::*;

  logic [PROD_W-1:0] prod;

  // multiply by the reciprocal, the quotient sits above the shift
  always_comb begin
    prod = PROD_W'(dividend) * PROD_W'(RECIP);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= prod[RECIP_SH +: TIME_W];
    end
  end

endmodule

>>> hw/rtl/periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Slot table of periodic tasks in one synchronous memory; tick, find, dispatch
// walk it one slot per cycle unless dispatch stalls; tick and dispatch write back.
// ----------------------------------------------------------------------------
// tick, find and dispatch walk the slots through the single read port; add waits
//   on the reciprocal multiply by the tick unit; delete, table full and unknown
//   go straight to the final result
// one request at a time, the next can be taken once the final result is presented;
//   dispatch results wait on m_tready and hold the walk
// reset clears the slot used flags and control; the memory is not cleared
module periodic_task_slot_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // task_key[31:0], start_delay[47:32], repeat_period[63:48],
  // slot_number[67:64], zero pad
  input  logic [ptss_pkg::S_DATA_W-1:0] s_tdata,
  // func[2:0]
  input  logic [ptss_pkg::FUNC_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // slot_index[3:0], ready_key[35:4], zero pad
  output logic [ptss_pkg::M_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [ptss_pkg::STATUS_W-1:0] m_tuser,
  output logic                          m_tlast
);
  import ptss_pkg::*;

  typedef enum logic [1:0] {IDLE, DIVIDE, WALK, FINISH} state_t;

  state_t             state;
  func_t              cmd;
  logic [KEY_W-1:0]   key_r;
  logic [SLOT_W-1:0]  free_idx_r;
  logic [SLOTS-1:0]   used;

  // walk pipeline
  logic [SLOT_W-1:0]  iss_idx;
  logic               iss_done;
  logic               p_vld;
  logic [SLOT_W-1:0]  p_idx;
  logic [CNT_W-1:0]   served;

  // result under construction (also the held dispatch result)
  status_t            fin_status;
  logic [SLOT_W-1:0]  fin_idx;
  logic [KEY_W-1:0]   fin_key;

  // table memory
  slot_t              mem [SLOTS];
  slot_t              rd_data;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  slot_t              wr_data;

  // request fields
  logic               accept;
  logic [KEY_W-1:0]   in_key;
  logic [TIME_W-1:0]  in_dly;
  logic [TIME_W-1:0]  in_per;
  logic [SN_W-1:0]    in_sn;
  func_t              in_func;

  // free slot search, divider
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               div_start;
  logic               dly_done;
  logic               per_done;
  logic [TIME_W-1:0]  dly_q;
  logic [TIME_W-1:0]  per_q;

  // walk control
  logic               p_used;
  logic               ready;
  logic               stall;
  logic               p_done;
  logic               issue;
  logic               out_free;
  logic               push;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_key   = s_tdata[31:0];
  assign in_dly   = s_tdata[47:32];
  assign in_per   = s_tdata[63:48];
  assign in_sn    = s_tdata[67:64];
  assign in_func  = func_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign div_start = accept && (in_func == FUNC_ADD) && free_found;

  ptss_div u_div_dly (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_dly),
    .done     (dly_done),
    .quotient (dly_q)
  );

  ptss_div u_div_per (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_per),
    .done     (per_done),
    .quotient (per_q)
  );

  // walk stage decode
  always_comb begin
    p_used = used[p_idx];
    ready  = (cmd == FUNC_DISPATCH) && p_used && (rd_data.pend != '0) &&
             (served < CNT_W'(MAX_RESULTS));
    stall  = p_vld && ready && (fin_status == ST_OK) && !out_free;
    p_done = p_vld && !stall;
    issue  = (state == WALK) && !iss_done && !stall;
    push   = (state == WALK) && p_done && ready && (fin_status == ST_OK);
  end

  // memory write port: add entry or walk write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx;
    wr_data = rd_data;
    if (state == DIVIDE) begin
      wr_en        = dly_done && per_done;
      wr_addr      = free_idx_r;
      wr_data.key  = key_r;
      wr_data.cd   = dly_q;
      wr_data.rl   = per_q;
      wr_data.pend = '0;
    end else if ((state == WALK) && p_done && p_used) begin
      case (cmd)
        FUNC_TICK: begin
          wr_en = 1'b1;
          if (rd_data.cd == '0) begin
            if (rd_data.pend != PEND_MAX) begin
              wr_data.pend = rd_data.pend + 1'b1;
            end
            if (rd_data.rl != '0) begin
              wr_data.cd = rd_data.rl;
            end
          end else begin
            wr_data.cd = rd_data.cd - 1'b1;
          end
        end
        FUNC_DISPATCH: begin
          wr_en        = ready;
          wr_data.pend = rd_data.pend - 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[iss_idx];
    end
  end

  // sequencer, used flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      used     <= '0;
      p_vld    <= 1'b0;
      iss_done <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            cmd        <= in_func;
            key_r      <= in_key;
            free_idx_r <= free_idx;
            fin_status <= ST_OK;
            fin_idx    <= '0;
            fin_key    <= '0;
            iss_idx    <= '0;
            iss_done   <= 1'b0;
            p_vld      <= 1'b0;
            served     <= '0;
            case (in_func)
              FUNC_TICK: begin
                state <= WALK;
              end
              FUNC_FIND: begin
                fin_status <= ST_NOT_FOUND;
                state      <= WALK;
              end
              FUNC_DISPATCH: begin
                fin_status <= ST_NONE;
                state      <= WALK;
              end
              FUNC_ADD: begin
                if (free_found) begin
                  fin_idx <= free_idx;
                  state   <= DIVIDE;
                end else begin
                  fin_status <= ST_FULL;
                  state      <= FINISH;
                end
              end
              FUNC_DELETE: begin
                if (32'(in_sn) >= 32'(SLOTS)) begin
                  fin_status <= ST_NOT_FOUND;
                end else begin
                  fin_idx             <= SLOT_W'(in_sn);
                  used[SLOT_W'(in_sn)] <= 1'b0;
                end
                state <= FINISH;
              end
              default: begin
                state <= FINISH;
              end
            endcase
          end
        end
        DIVIDE: begin
          if (dly_done && per_done) begin
            used[free_idx_r] <= 1'b1;
            state            <= FINISH;
          end
        end
        WALK: begin
          // issue stage
          if (issue) begin
            p_vld <= 1'b1;
            p_idx <= iss_idx;
            if (iss_idx == SLOT_W'(SLOTS - 1)) begin
              iss_done <= 1'b1;
            end else begin
              iss_idx <= iss_idx + 1'b1;
            end
          end else if (p_done) begin
            p_vld <= 1'b0;
          end
          // process stage
          if (p_done) begin
            if ((cmd == FUNC_FIND) && p_used && (rd_data.key == key_r) &&
                (fin_status != ST_OK)) begin
              fin_status <= ST_OK;
              fin_idx    <= p_idx;
            end
            if (ready) begin
              served     <= served + 1'b1;
              fin_status <= ST_OK;
              fin_idx    <= p_idx;
              fin_key    <= rd_data.key;
              if (rd_data.rl == '0) begin
                used[p_idx] <= 1'b0;
              end
            end
          end
          // previously held dispatch result goes out, more may follow
          if (push) begin
            m_tvalid <= 1'b1;
            m_tuser  <= fin_status;
            m_tdata  <= {4'b0, fin_key, IDX_W'(fin_idx)};
            m_tlast  <= 1'b0;
          end
          if (iss_done && (!p_vld || p_done)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= fin_status;
            m_tdata  <= {4'b0, fin_key, IDX_W'(fin_idx)};
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/ptss_chk.sv
// ----------------------------------------------------------------------------
// ptss_chk
// Port-level checks of the periodic task slot scheduler, bound to the top.
// ----------------------------------------------------------------------------
module ptss_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ptss_pkg::M_DATA_W-1:0] m_tdata,
  input logic [ptss_pkg::STATUS_W-1:0] m_tuser,
  input logic                          m_tlast
);
  import ptss_pkg::*;

  // one request at a time: no request taken right after another
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                              $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  // nothing-ready result is single, with zero slot and key
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NONE) |-> m_tlast && (m_tdata == '0))
    else $error("nothing-ready result malformed");

  // only dispatched tasks come in runs of several results
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tuser == ST_OK))
    else $error("non-final result with error status");

endmodule

bind periodic_task_slot_scheduler ptss_chk u_ptss_chk (.*);
